// File: hdl/efpx_pkg.sv
// shared types and constants for the escaped frame parser with xor check
`default_nettype none

package efpx_pkg;

  localparam int unsigned EFPX_NUM_TYPES = 4;
  localparam int unsigned EFPX_MAX_TYPES = 4;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 32;

  localparam logic [7:0] START_BYTE_RST  = 8'd126;
  localparam logic [7:0] END_BYTE_RST    = 8'd127;
  localparam logic [7:0] ESCAPE_BYTE_RST = 8'd125;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_BYTE   = 3'd0,
    CFG_END_BYTE     = 3'd1,
    CFG_ESCAPE_BYTE  = 3'd2,
    CFG_TYPE_LABELS  = 3'd3,
    CFG_TYPE_LENGTHS = 3'd4,
    CFG_TYPE_ENABLE  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_SEEK_START = 2'd0,
    PH_SEEK_LABEL = 2'd1,
    PH_BODY       = 2'd2,
    PH_SEEK_END   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_START  = 3'd1,
    ERR_BAD_LABEL = 3'd2,
    ERR_CHECKSUM  = 3'd3,
    ERR_NO_END    = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [7:0]  escape_byte;
    logic [31:0] type_labels;
    logic [31:0] type_lengths;
    logic [3:0]  type_enable;
  } cfg_t;

  typedef struct packed {
    phase_e     phase_after;
    err_e       error_code;
    logic       frame_done;
    logic [1:0] type_index;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_pos;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/efpx_stream_if.sv
// valid/ready stream interfaces for received bytes and parser results
`default_nettype none

interface efpx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efpx_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] phase_after;
  logic [2:0] error_code;
  logic       frame_done;
  logic [1:0] type_index;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_pos;

  modport source (
    output valid, output phase_after, output error_code, output frame_done,
    output type_index, output payload_valid, output payload_byte, output payload_pos,
    input ready
  );
  modport sink (
    input valid, input phase_after, input error_code, input frame_done,
    input type_index, input payload_valid, input payload_byte, input payload_pos,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/efpx_cfg_regs.sv
// configuration register file with plain write port
`default_nettype none

module efpx_cfg_regs
  import efpx_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_BYTE:   cfg_d.start_byte   = cfg_wdata_i[7:0];
        CFG_END_BYTE:     cfg_d.end_byte     = cfg_wdata_i[7:0];
        CFG_ESCAPE_BYTE:  cfg_d.escape_byte  = cfg_wdata_i[7:0];
        CFG_TYPE_LABELS:  cfg_d.type_labels  = cfg_wdata_i[31:0];
        CFG_TYPE_LENGTHS: cfg_d.type_lengths = cfg_wdata_i[31:0];
        CFG_TYPE_ENABLE:  cfg_d.type_enable  = cfg_wdata_i[3:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte   <= START_BYTE_RST;
      cfg_q.end_byte     <= END_BYTE_RST;
      cfg_q.escape_byte  <= ESCAPE_BYTE_RST;
      cfg_q.type_labels  <= '0;
      cfg_q.type_lengths <= '0;
      cfg_q.type_enable  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hdl/efpx_label_match.sv
// parallel label compare against enabled message types, lowest index wins
`default_nettype none

module efpx_label_match
  import efpx_pkg::*;
#(
  parameter int unsigned NumTypes = EFPX_NUM_TYPES
) (
  input  wire logic [7:0]  label_i,
  input  wire logic [31:0] type_labels_i,
  input  wire logic [3:0]  type_enable_i,
  output logic             found_o,
  output logic [1:0]       type_idx_o
);

  always_comb begin
    found_o    = 1'b0;
    type_idx_o = '0;
    for (int i = NumTypes - 1; i >= 0; i--) begin
      if (type_enable_i[i] && (type_labels_i[8*i +: 8] == label_i)) begin
        found_o    = 1'b1;
        type_idx_o = 2'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/efpx_parser_core.sv
// frame state registers and per-byte step logic
`default_nettype none

module efpx_parser_core
  import efpx_pkg::*;
#(
  parameter int unsigned NumTypes = EFPX_NUM_TYPES
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire cfg_t       cfg_i,
  output result_t         res_o
);

  phase_e     phase_q, phase_d;
  logic [1:0] type_q, type_d;
  logic [7:0] count_q, count_d;
  logic [7:0] xor_q, xor_d;
  logic       esc_q, esc_d;

  logic       found;
  logic [1:0] match_idx;
  logic [7:0] cur_len;

  efpx_label_match #(
    .NumTypes (NumTypes)
  ) u_match (
    .label_i       (rx_byte_i),
    .type_labels_i (cfg_i.type_labels),
    .type_enable_i (cfg_i.type_enable),
    .found_o       (found),
    .type_idx_o    (match_idx)
  );

  assign cur_len = cfg_i.type_lengths[8*type_q +: 8];

  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    count_d = count_q;
    xor_d   = xor_q;
    esc_d   = esc_q;

    res_o.error_code    = ERR_NONE;
    res_o.frame_done    = 1'b0;
    res_o.payload_valid = 1'b0;
    res_o.payload_byte  = '0;
    res_o.payload_pos   = '0;

    unique case (phase_q)
      PH_SEEK_START: begin
        if (rx_byte_i == cfg_i.start_byte) phase_d = PH_SEEK_LABEL;
        else res_o.error_code = ERR_NO_START;
      end
      PH_SEEK_LABEL: begin
        if (found) begin
          phase_d = PH_BODY;
          type_d  = match_idx;
          count_d = '0;
          xor_d   = rx_byte_i;
          esc_d   = 1'b0;
        end else begin
          phase_d          = PH_SEEK_START;
          res_o.error_code = ERR_BAD_LABEL;
        end
      end
      PH_BODY: begin
        priority if (count_q >= cur_len) begin
          if (rx_byte_i == xor_q) begin
            phase_d = PH_SEEK_END;
          end else begin
            phase_d          = PH_SEEK_START;
            res_o.error_code = ERR_CHECKSUM;
          end
        end else if (!esc_q && (rx_byte_i == cfg_i.escape_byte)) begin
          esc_d = 1'b1;
        end else begin
          esc_d               = 1'b0;
          res_o.payload_valid = 1'b1;
          res_o.payload_byte  = rx_byte_i;
          res_o.payload_pos   = count_q;
          xor_d               = xor_q ^ rx_byte_i;
          count_d             = count_q + 8'd1;
        end
      end
      PH_SEEK_END: begin
        phase_d = PH_SEEK_START;
        if (rx_byte_i == cfg_i.end_byte) res_o.frame_done = 1'b1;
        else res_o.error_code = ERR_NO_END;
      end
      default: phase_d = PH_SEEK_START;
    endcase

    res_o.phase_after = phase_d;
    res_o.type_index  = type_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK_START;
      type_q  <= '0;
      count_q <= '0;
      xor_q   <= '0;
      esc_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      type_q  <= type_d;
      count_q <= count_d;
      xor_q   <= xor_d;
      esc_q   <= esc_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/escaped_frame_parser_xor_check_unit.sv
// Byte-stuffed frame parser with XOR checksum. Received bytes enter through a
// valid/ready input register, one step of the frame state machine (start,
// label, payload with escapes, checksum, end) runs between that register and
// the result register, and one result per byte leaves on the output channel.
// A byte is accepted every cycle as long as results are taken; a byte's result
// becomes valid on the output once the step from the input register has been
// caught in the result register, which holds while an earlier result is untaken.
// Configuration registers are written through the plain write port, by the user only
// while the block is idle (not enforced by the block); no clearing pass after reset.
`default_nettype none

module escaped_frame_parser_xor_check_unit
  import efpx_pkg::*;
#(
  parameter int unsigned NumTypes = EFPX_NUM_TYPES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  efpx_in_if.sink                    in_if,
  efpx_out_if.source                 out_if
);

  cfg_t       cfg;
  result_t    step_res;
  result_t    res_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic       out_free;
  logic       step;

  efpx_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign out_free     = !out_valid_q || out_if.ready;
  assign step         = in_valid_q && out_free;
  assign in_if.ready  = !in_valid_q || out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_q <= in_if.rx_byte;
    end
  end

  efpx_parser_core #(
    .NumTypes (NumTypes)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg),
    .res_o     (step_res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= step_res;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.phase_after   = res_q.phase_after;
  assign out_if.error_code    = res_q.error_code;
  assign out_if.frame_done    = res_q.frame_done;
  assign out_if.type_index    = res_q.type_index;
  assign out_if.payload_valid = res_q.payload_valid;
  assign out_if.payload_byte  = res_q.payload_byte;
  assign out_if.payload_pos   = res_q.payload_pos;

endmodule

`default_nettype wire

// File: verif/tb.sv
// self-checking testbench for the escaped frame parser with xor check
module tb
  import efpx_pkg::*;
;

  localparam int unsigned NUM_ROWS     = 26;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned PHASE_BYTES  = 125;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned STALL_LIMIT  = 2000;

  typedef struct {
    logic        is_cfg;
    cfg_idx_e    idx;
    logic [31:0] data;
    logic [7:0]  rx;
    logic        typed;
    result_t     want;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  efpx_in_if  in_ch ();
  efpx_out_if out_ch ();

  escaped_frame_parser_xor_check_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // parser state and register copy
  cfg_t       regs;
  phase_e     ph;
  logic [1:0] cur_type;
  logic [7:0] pay_cnt;
  logic [7:0] run_xor;
  logic       esc_pend;

  result_t     pending_results[$];
  row_t        dir_rows[NUM_ROWS];
  int unsigned n_in = 0;
  int unsigned n_out = 0;
  int unsigned n_frames = 0;
  int unsigned n_payload = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned err_seen[5] = '{default: 0};
  logic        hold_done = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // lowest enabled index with a matching label wins
  function automatic logic find_type(input logic [7:0] label, output logic [1:0] idx);
    logic hit;
    hit = 1'b0;
    idx = '0;
    for (int i = EFPX_NUM_TYPES - 1; i >= 0; i--) begin
      if (regs.type_enable[i] && regs.type_labels[8*i +: 8] == label) begin
        hit = 1'b1;
        idx = i[1:0];
      end
    end
    return hit;
  endfunction

  function automatic result_t model_step(input logic [7:0] rx);
    result_t    r;
    logic [1:0] t;
    logic [7:0] len;
    r = '0;
    r.error_code = ERR_NONE;
    case (ph)
      PH_SEEK_START: begin
        if (rx == regs.start_byte) ph = PH_SEEK_LABEL;
        else r.error_code = ERR_NO_START;
      end
      PH_SEEK_LABEL: begin
        if (find_type(rx, t)) begin
          cur_type = t;
          ph       = PH_BODY;
          pay_cnt  = 8'd0;
          run_xor  = rx;
          esc_pend = 1'b0;
        end else begin
          r.error_code = ERR_BAD_LABEL;
          ph           = PH_SEEK_START;
        end
      end
      PH_BODY: begin
        len = regs.type_lengths[8*cur_type +: 8];
        if (pay_cnt >= len) begin
          if (rx == run_xor) begin
            ph = PH_SEEK_END;
          end else begin
            r.error_code = ERR_CHECKSUM;
            ph           = PH_SEEK_START;
          end
        end else if (!esc_pend && rx == regs.escape_byte) begin
          esc_pend = 1'b1;
        end else begin
          esc_pend        = 1'b0;
          r.payload_valid = 1'b1;
          r.payload_byte  = rx;
          r.payload_pos   = pay_cnt;
          run_xor         = run_xor ^ rx;
          pay_cnt         = pay_cnt + 8'd1;
        end
      end
      default: begin
        ph = PH_SEEK_START;
        if (rx == regs.end_byte) r.frame_done = 1'b1;
        else r.error_code = ERR_NO_END;
      end
    endcase
    r.phase_after = ph;
    r.type_index  = cur_type;
    return r;
  endfunction

  function automatic result_t status_only(phase_e p, err_e e, logic done, logic [1:0] t);
    result_t r;
    r = '0;
    r.phase_after = p;
    r.error_code  = e;
    r.frame_done  = done;
    r.type_index  = t;
    return r;
  endfunction

  function automatic row_t rx_row(logic [7:0] rx, logic typed = 1'b0, result_t want = '0);
    row_t row;
    row = '{1'b0, CFG_START_BYTE, 32'd0, rx, typed, want};
    return row;
  endfunction

  function automatic row_t reg_row(cfg_idx_e idx, logic [31:0] val);
    row_t row;
    row = '{1'b1, idx, val, 8'd0, 1'b0, '0};
    return row;
  endfunction

  // no idling on either side in a window of the run
  function automatic logic take_break();
    return (n_in < 500 || n_in >= 700) && $urandom_range(0, 99) < 7;
  endfunction

  task automatic set_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_START_BYTE:   regs.start_byte   = val[7:0];
      CFG_END_BYTE:     regs.end_byte     = val[7:0];
      CFG_ESCAPE_BYTE:  regs.escape_byte  = val[7:0];
      CFG_TYPE_LABELS:  regs.type_labels  = val;
      CFG_TYPE_LENGTHS: regs.type_lengths = val;
      CFG_TYPE_ENABLE:  regs.type_enable  = val[3:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] rx, input logic typed, input result_t want);
    result_t r;
    while (take_break()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= rx;
    do @(posedge clk_i); while (!in_ch.ready);
    r = model_step(rx);
    pending_results.push_back(typed ? want : r);
    n_in++;
    err_seen[r.error_code]++;
    if (r.frame_done) n_frames++;
    if (r.payload_valid) n_payload++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // mostly well-formed frames, some noise, bad checksums, bad ends and cut frames
  task automatic send_frame();
    logic [7:0]  fb[$];
    logic [7:0]  label;
    logic [7:0]  v;
    logic [7:0]  sum;
    logic [1:0]  t;
    int unsigned len;
    int unsigned cut;
    fb = {};
    if ($urandom_range(0, 9) == 0) fb.push_back(8'($urandom_range(0, 255)));
    fb.push_back(regs.start_byte);
    if (regs.type_enable == 4'h0 || $urandom_range(0, 19) == 0) begin
      label = 8'($urandom_range(0, 255));
    end else begin
      do t = 2'($urandom_range(0, 3)); while (!regs.type_enable[t]);
      label = regs.type_labels[8*t +: 8];
    end
    fb.push_back(label);
    if (find_type(label, t)) begin
      len = regs.type_lengths[8*t +: 8];
      sum = label;
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 7))
          0: v = regs.escape_byte;
          1: v = regs.start_byte;
          2: v = regs.end_byte;
          default: v = 8'($urandom_range(0, 255));
        endcase
        if (v == regs.escape_byte || $urandom_range(0, 7) == 0) fb.push_back(regs.escape_byte);
        fb.push_back(v);
        sum = sum ^ v;
      end
      fb.push_back($urandom_range(0, 9) == 0 ? sum ^ 8'($urandom_range(1, 255)) : sum);
      fb.push_back($urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255)) : regs.end_byte);
    end
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, fb.size()) : fb.size();
    for (int k = 0; k < cut; k++) send_byte(fb[k], 1'b0, '0);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && n_in >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_ch.ready <= !take_break();
      end
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cycles = 0;
    else stall_cycles++;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      n_out++;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("phase_after", want.phase_after, out_ch.phase_after);
        check_field("error_code", want.error_code, out_ch.error_code);
        check_field("frame_done", want.frame_done, out_ch.frame_done);
        check_field("type_index", want.type_index, out_ch.type_index);
        check_field("payload_valid", want.payload_valid, out_ch.payload_valid);
        check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
        check_field("payload_pos", want.payload_pos, out_ch.payload_pos);
      end
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $error("no transfer for %0d cycles, %0d results outstanding",
           stall_cycles, pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [7:0]  sb;
    logic [7:0]  eb;
    logic [7:0]  xb;
    logic [31:0] lab;
    logic [31:0] lens;
    logic [3:0]  en;
    logic        writing;
    logic        paused;
    int unsigned sent0;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_START_BYTE;
    cfg_wdata_i   = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'd0;

    regs.start_byte   = START_BYTE_RST;
    regs.end_byte     = END_BYTE_RST;
    regs.escape_byte  = ESCAPE_BYTE_RST;
    regs.type_labels  = 32'd0;
    regs.type_lengths = 32'd0;
    regs.type_enable  = 4'd0;
    ph       = PH_SEEK_START;
    cur_type = 2'd0;
    pay_cnt  = 8'd0;
    run_xor  = 8'd0;
    esc_pend = 1'b0;

    dir_rows = '{
      rx_row(8'h00, 1'b1, status_only(PH_SEEK_START, ERR_NO_START, 1'b0, 2'd0)),
      rx_row(8'hFF, 1'b1, status_only(PH_SEEK_START, ERR_NO_START, 1'b0, 2'd0)),
      rx_row(8'h7E, 1'b1, status_only(PH_SEEK_LABEL, ERR_NONE, 1'b0, 2'd0)),
      // no type enabled yet
      rx_row(8'h41, 1'b1, status_only(PH_SEEK_START, ERR_BAD_LABEL, 1'b0, 2'd0)),
      reg_row(CFG_TYPE_LABELS, 32'hFF41_4100),
      reg_row(CFG_TYPE_LENGTHS, 32'h0103_0002),
      reg_row(CFG_TYPE_ENABLE, 32'h0000_000F),
      // escaped escape and start byte as payload
      rx_row(8'h7E), rx_row(8'h00), rx_row(8'h7D), rx_row(8'h7D), rx_row(8'h7E), rx_row(8'h03),
      rx_row(8'h7F, 1'b1, status_only(PH_SEEK_START, ERR_NONE, 1'b1, 2'd0)),
      // zero length, first of two matching labels, wrong end byte
      rx_row(8'h7E), rx_row(8'h41), rx_row(8'h41),
      rx_row(8'h00, 1'b1, status_only(PH_SEEK_START, ERR_NO_END, 1'b0, 2'd1)),
      // one-byte payload, checksum equal to escape byte
      rx_row(8'h7E), rx_row(8'hFF), rx_row(8'h82), rx_row(8'h7D),
      rx_row(8'h7F, 1'b1, status_only(PH_SEEK_START, ERR_NONE, 1'b1, 2'd3)),
      rx_row(8'h7E), rx_row(8'h41),
      rx_row(8'h00, 1'b1, status_only(PH_SEEK_START, ERR_CHECKSUM, 1'b0, 2'd1))
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    writing = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        if (!writing) drain();
        set_reg(dir_rows[i].idx, dir_rows[i].data);
        writing = 1'b1;
      end else begin
        if (writing) cfg_we_i <= 1'b0;
        writing = 1'b0;
        send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      sb   = 8'($urandom_range(0, 255));
      eb   = 8'($urandom_range(0, 255));
      xb   = 8'($urandom_range(0, 255));
      lab  = $urandom();
      lens = 32'd0;
      en   = 4'($urandom_range(1, 15));
      for (int k = 0; k < 4; k++) lens[8*k +: 8] = 8'($urandom_range(0, 6));
      case (p)
        0: begin
          sb = 8'h00;
          eb = 8'hFF;
          en = 4'hF;
        end
        1: begin
          sb  = 8'hFF;
          eb  = 8'h00;
          lab = 32'h0;
        end
        2: begin
          xb  = 8'h00;
          lab = 32'hFFFF_FFFF;
        end
        3: xb = 8'hFF;
        4: lens[8*$urandom_range(0, 3) +: 8] = 8'hFF;
        5: lens = 32'h0;
        6: en = 4'h0;
        7: en = 4'h8;
        default: ;
      endcase
      drain();
      set_reg(CFG_START_BYTE, {24'd0, sb});
      set_reg(CFG_END_BYTE, {24'd0, eb});
      set_reg(CFG_ESCAPE_BYTE, {24'd0, xb});
      set_reg(CFG_TYPE_LABELS, lab);
      set_reg(CFG_TYPE_LENGTHS, lens);
      set_reg(CFG_TYPE_ENABLE, {28'd0, en});
      cfg_we_i <= 1'b0;
      sent0  = n_in;
      paused = 1'b0;
      while (n_in - sent0 < PHASE_BYTES) begin
        if (p == 3 && !paused && n_in - sent0 >= 60) begin
          drain();
          paused = 1'b1;
        end
        send_frame();
      end
    end

    drain();
    $display("run covered %0d bytes and %0d checked results over %0d register settings",
             n_in, n_out, NUM_PHASES + 2);
    $display("%0d frames closed, %0d payload bytes, errors: start %0d label %0d sum %0d end %0d",
             n_frames, n_payload, err_seen[ERR_NO_START], err_seen[ERR_BAD_LABEL],
             err_seen[ERR_CHECKSUM], err_seen[ERR_NO_END]);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/efpx_pkg.sv
hdl/efpx_stream_if.sv
hdl/efpx_cfg_regs.sv
hdl/efpx_label_match.sv
hdl/efpx_parser_core.sv
hdl/escaped_frame_parser_xor_check_unit.sv
verif/tb.sv
